### design/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// shared types and constants for the character lcd nibble write sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_DATA  = 3'd1,
        CMD_INSTR = 3'd2,
        CMD_ADDR  = 3'd3,
        CMD_CLEAR = 3'd4,
        CMD_INIT  = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_PWR  = 4'd1,
        PH_ISET = 4'd2,
        PH_IHI  = 4'd3,
        PH_ILO  = 4'd4,
        PH_USET = 4'd5,
        PH_UHI  = 4'd6,
        PH_LHI  = 4'd7,
        PH_HOLD = 4'd8,
        PH_CLRW = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        CFG_SETUP      = 2'd0,
        CFG_INIT_PHASE = 2'd1,
        CFG_POWER_UP   = 2'd2,
        CFG_CLEAR_WAIT = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] SETUP_RST      = 16'd200;
    localparam logic [15:0] INIT_PHASE_RST = 16'd2000;
    localparam logic [15:0] POWER_UP_RST   = 16'd4000;
    localparam logic [15:0] CLEAR_WAIT_RST = 16'd10000;

    localparam logic [7:0] ADDR_FLAG   = 8'h80;
    localparam logic [7:0] CLEAR_INSTR = 8'h01;

    // power-up nibble table, entries past the twelfth are zero
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        begin
            case (idx)
                4'd0:    nib = 4'h3;
                4'd1:    nib = 4'h3;
                4'd2:    nib = 4'h3;
                4'd3:    nib = 4'h2;
                4'd4:    nib = 4'h2;
                4'd5:    nib = 4'h8;
                4'd6:    nib = 4'h0;
                4'd7:    nib = 4'hC;
                4'd8:    nib = 4'h0;
                4'd9:    nib = 4'h1;
                4'd10:   nib = 4'h0;
                4'd11:   nib = 4'h6;
                default: nib = 4'h0;
            endcase
            return nib;
        end
    endfunction

endpackage

`default_nettype wire

### design/char_lcd_nibble_write_sequencer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_core
// timed pin sequencer for a 4-bit character lcd bus
// ----------------------------------------------------------------------------
// usage:
//   each word on the s_axis channel is one time tick; tuser carries the
//   command (tick, data byte, instruction byte, set address, clear, init)
//   and tdata the byte. a command taken while idle starts a sequence: either
//   power-up init (all-low wait, then the init nibble table with setup,
//   enable-high and enable-low phases) or a byte write (upper nibble setup,
//   upper enable pulse, lower enable pulse, hold, plus an extra wait after
//   clear). a command arriving while busy is dropped and flagged.
//   every input word yields exactly one output word on m_axis holding the
//   pin levels after that tick, the busy flag and the rejected flag.
// throughput:
//   one word per cycle while the output is not stalled; the result is
//   captured in a single output register fed by the phase/counter update.
// stall:
//   s_axis_tready drops only while the output register is full and
//   m_axis_tready is low; no word is lost or repeated.
// reset:
//   rst_n clears the sequencer to idle with all pins low and the timing
//   registers to their defaults. the cfg channel is always ready and should
//   be written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_write_sequencer_core #(
    parameter int INIT_LEN    = 12,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] cmd
    // result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [3:0] bus_nibble, [4] reg_select,
                                             // [5] enable_line, [6] busy_res,
                                             // [7] rejected
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam logic [32:0] CMAX = (33'd1 << COUNT_WIDTH) - 33'd1;
    localparam logic [4:0]  INIT_LEN_V = 5'(INIT_LEN);

    // phase length: zero counts as one tick, saturates to the counter range
    function automatic logic [COUNT_WIDTH-1:0] ticks_of(input logic [15:0] v);
        logic [32:0] t;
        begin
            t = 33'(v);
            if (t > CMAX) t = CMAX;
            if (t == 33'd0) t = 33'd1;
            return t[COUNT_WIDTH-1:0];
        end
    endfunction

    // timing registers
    logic [15:0] setup_reg, init_phase_reg, power_up_reg, clear_wait_reg;

    // sequencer state
    lcdseq_pkg::phase_t       phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;
    logic [7:0]               held_byte_reg, held_byte_next;
    logic                     held_data_reg, held_data_next;
    logic                     clr_pend_reg, clr_pend_next;
    logic [3:0]               init_idx_reg, init_idx_next;
    logic [5:0]               pins_reg, pins_next;

    // output register
    logic                     out_valid_reg;
    logic [7:0]               out_data_reg;

    logic                     s_fire;
    logic                     rej;
    logic                     do_enter;
    lcdseq_pkg::phase_t       tgt;
    logic [COUNT_WIDTH-1:0]   count_dec;
    logic                     is_cmd;
    logic [3:0]               idx_inc;
    logic [3:0]               nib;
    logic [3:0]               hi_nib, lo_nib;
    logic                     rs_bit;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_reg      <= lcdseq_pkg::SETUP_RST;
            init_phase_reg <= lcdseq_pkg::INIT_PHASE_RST;
            power_up_reg   <= lcdseq_pkg::POWER_UP_RST;
            clear_wait_reg <= lcdseq_pkg::CLEAR_WAIT_RST;
        end
        else if (cfg_valid)
        begin
            case (lcdseq_pkg::cfg_idx_t'(cfg_index))
                lcdseq_pkg::CFG_SETUP:      setup_reg      <= cfg_data;
                lcdseq_pkg::CFG_INIT_PHASE: init_phase_reg <= cfg_data;
                lcdseq_pkg::CFG_POWER_UP:   power_up_reg   <= cfg_data;
                lcdseq_pkg::CFG_CLEAR_WAIT: clear_wait_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        held_byte_next = held_byte_reg;
        held_data_next = held_data_reg;
        clr_pend_next  = clr_pend_reg;
        init_idx_next  = init_idx_reg;
        pins_next      = pins_reg;
        rej            = 1'b0;
        do_enter       = 1'b0;
        tgt            = lcdseq_pkg::PH_IDLE;
        is_cmd         = (s_axis_tuser >= 3'(lcdseq_pkg::CMD_DATA)) &&
                         (s_axis_tuser <= 3'(lcdseq_pkg::CMD_INIT));
        count_dec      = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
        idx_inc        = init_idx_reg + 4'd1;

        if (phase_reg != lcdseq_pkg::PH_IDLE)
        begin
            // busy: every word is one tick, commands are dropped
            rej        = is_cmd;
            count_next = count_dec;
            if (count_dec == '0)
            begin
                do_enter = 1'b1;
                case (phase_reg)
                    lcdseq_pkg::PH_PWR:
                    begin
                        init_idx_next = 4'd0;
                        tgt = lcdseq_pkg::PH_ISET;
                    end
                    lcdseq_pkg::PH_ISET: tgt = lcdseq_pkg::PH_IHI;
                    lcdseq_pkg::PH_IHI:  tgt = lcdseq_pkg::PH_ILO;
                    lcdseq_pkg::PH_ILO:
                    begin
                        init_idx_next = idx_inc;
                        if (idx_inc != 4'd0 && {1'b0, idx_inc} < INIT_LEN_V)
                            tgt = lcdseq_pkg::PH_ISET;
                        else
                            tgt = lcdseq_pkg::PH_IDLE;
                    end
                    lcdseq_pkg::PH_USET: tgt = lcdseq_pkg::PH_UHI;
                    lcdseq_pkg::PH_UHI:  tgt = lcdseq_pkg::PH_LHI;
                    lcdseq_pkg::PH_LHI:  tgt = lcdseq_pkg::PH_HOLD;
                    lcdseq_pkg::PH_HOLD:
                    begin
                        if (clr_pend_reg && clear_wait_reg != 16'd0)
                            tgt = lcdseq_pkg::PH_CLRW;
                        else
                            tgt = lcdseq_pkg::PH_IDLE;
                        clr_pend_next = 1'b0;
                    end
                    default: tgt = lcdseq_pkg::PH_IDLE;
                endcase
            end
        end
        else
        begin
            case (lcdseq_pkg::cmd_t'(s_axis_tuser))
                lcdseq_pkg::CMD_DATA:
                begin
                    do_enter = 1'b1; tgt = lcdseq_pkg::PH_USET;
                    held_byte_next = s_axis_tdata;
                    held_data_next = 1'b1; clr_pend_next = 1'b0;
                end
                lcdseq_pkg::CMD_INSTR:
                begin
                    do_enter = 1'b1; tgt = lcdseq_pkg::PH_USET;
                    held_byte_next = s_axis_tdata;
                    held_data_next = 1'b0; clr_pend_next = 1'b0;
                end
                lcdseq_pkg::CMD_ADDR:
                begin
                    do_enter = 1'b1; tgt = lcdseq_pkg::PH_USET;
                    held_byte_next = s_axis_tdata | lcdseq_pkg::ADDR_FLAG;
                    held_data_next = 1'b0; clr_pend_next = 1'b0;
                end
                lcdseq_pkg::CMD_CLEAR:
                begin
                    do_enter = 1'b1; tgt = lcdseq_pkg::PH_USET;
                    held_byte_next = lcdseq_pkg::CLEAR_INSTR;
                    held_data_next = 1'b0; clr_pend_next = 1'b1;
                end
                lcdseq_pkg::CMD_INIT:
                begin
                    do_enter = 1'b1; tgt = lcdseq_pkg::PH_PWR;
                    init_idx_next = 4'd0;
                end
                default: ;
            endcase
        end

        // phase entry: load the phase length and drive the pins
        nib    = lcdseq_pkg::init_nibble(init_idx_next);
        hi_nib = held_byte_next[7:4];
        lo_nib = held_byte_next[3:0];
        rs_bit = held_data_next;
        if (do_enter)
        begin
            phase_next = tgt;
            case (tgt)
                lcdseq_pkg::PH_PWR:
                begin
                    count_next = ticks_of(power_up_reg);
                    pins_next  = 6'd0;
                end
                lcdseq_pkg::PH_ISET, lcdseq_pkg::PH_ILO:
                begin
                    count_next = ticks_of(init_phase_reg);
                    pins_next  = {2'b00, nib};
                end
                lcdseq_pkg::PH_IHI:
                begin
                    count_next = ticks_of(init_phase_reg);
                    pins_next  = {2'b10, nib};
                end
                lcdseq_pkg::PH_USET:
                begin
                    count_next = ticks_of(setup_reg);
                    pins_next  = {2'b00, hi_nib};
                end
                lcdseq_pkg::PH_UHI:
                begin
                    count_next = ticks_of(setup_reg);
                    pins_next  = {1'b1, rs_bit, hi_nib};
                end
                lcdseq_pkg::PH_LHI:
                begin
                    count_next = ticks_of(setup_reg);
                    pins_next  = {1'b1, rs_bit, lo_nib};
                end
                lcdseq_pkg::PH_HOLD:
                begin
                    count_next = ticks_of(setup_reg);
                    pins_next  = {2'b00, lo_nib};
                end
                lcdseq_pkg::PH_CLRW:
                begin
                    count_next = ticks_of(clear_wait_reg);
                end
                default:
                begin
                    phase_next = lcdseq_pkg::PH_IDLE;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lcdseq_pkg::PH_IDLE;
            count_reg     <= '0;
            held_byte_reg <= 8'd0;
            held_data_reg <= 1'b0;
            clr_pend_reg  <= 1'b0;
            init_idx_reg  <= 4'd0;
            pins_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                held_byte_reg <= held_byte_next;
                held_data_reg <= held_data_next;
                clr_pend_reg  <= clr_pend_next;
                init_idx_reg  <= init_idx_next;
                pins_reg      <= pins_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_data_reg <= {rej, (phase_next != lcdseq_pkg::PH_IDLE), pins_next};
        end
    end

endmodule

`default_nettype wire
